### src/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared widths, defaults and types of the multichannel moving average.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mma_pkg;

    localparam int CHANNEL_W    = 2;
    localparam int SAMPLE_W     = 16;
    localparam int AVERAGE_W    = 16;
    localparam int S_TDATA_W    = 24;   // channel + sample, padded to bytes
    localparam int M_TDATA_W    = 16;   // average

    localparam int DEF_CHANNELS = 4;
    localparam int DEF_WINDOW   = 16;

    // One queued item, already classified by the front end
    typedef struct packed {
        logic                 in_range;
        logic [CHANNEL_W-1:0] channel;
        logic [SAMPLE_W-1:0]  sample;
    } item_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

endpackage

### src/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Boxcar moving average over WINDOW samples for CHANNELS independent channels.
// ----------------------------------------------------------------------------
// Each item carries a channel number and a 16-bit unsigned sample; each
// accepted item yields one result item, the floor of that channel's window
// sum divided by WINDOW, in the order the items came in. The block takes one
// item per clock cycle sustained while the output is not stalled; a result is
// registered in the queue, in the ring and in the divider. The rate is set by
// the read-modify-write of the per-channel sum and the one read plus one
// write per cycle on the sample memory. After reset all stored samples
// read as zero, so the first WINDOW-1 results of a channel average in zeros;
// this is tracked with a per-channel filled flag, so there is no clearing pass
// and items are taken from the first cycle after reset. An item whose channel
// is not below CHANNELS leaves all state alone and gives an average of zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_moving_average
    import mma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int WINDOW   = DEF_WINDOW
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [1:0] channel, [17:2] sample, rest zero
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [15:0] average
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);

    q_head_t              head;
    logic                 back_en;      // whole back end advances one step
    logic                 pop;
    logic                 sum_valid;
    logic [SUM_W-1:0]     sum;
    logic [AVERAGE_W-1:0] average;

    // Back end moves whenever the output register is free or being drained
    assign back_en = !m_tvalid || m_tready;
    assign pop     = back_en && head.valid;

    // Front end: classify and queue
    mma_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_channel (s_tdata[CHANNEL_W-1:0]),
        .s_sample  (s_tdata[CHANNEL_W+SAMPLE_W-1:CHANNEL_W]),
        .pop       (pop),
        .head      (head)
    );

    // Ring memory and running sums
    mma_ring #(
        .CHANNELS (CHANNELS),
        .WINDOW   (WINDOW)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (back_en),
        .load      (pop),
        .item      (head.item),
        .sum_valid (sum_valid),
        .sum_out   (sum)
    );

    // Constant divide and output register
    mma_div #(
        .WINDOW (WINDOW)
    ) u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (back_en),
        .in_valid    (sum_valid),
        .in_sum      (sum),
        .out_valid   (m_tvalid),
        .out_average (average)
    );

    assign m_tdata = M_TDATA_W'(average);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A full queue always presents a head item
    a_full_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> head.valid)
        else $error("queue full but head not valid");

    // Queue can only fill up while the back end is stalled
    a_fill_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(!back_en))
        else $error("queue filled while back end was running");

    // Reset leaves the block empty and ready once it is released
    a_reset_empty: assert property (@(posedge aclk)
        ($past(!aresetn) && aresetn) |-> (!m_tvalid && s_tready && !head.valid))
        else $error("block not empty after reset");

endmodule

### src/mma_front.sv
// ----------------------------------------------------------------------------
// mma_front
// Input side: takes items, flags out-of-range channels, two-entry queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_front
    import mma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [CHANNEL_W-1:0] s_channel,
    input  logic [SAMPLE_W-1:0]  s_sample,
    input  logic                 pop,
    output q_head_t              head
);

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop_ok;
    item_t      new_item;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop_ok  = pop && (count_reg != 2'd0);

    always_comb begin
        new_item.in_range = (32'(s_channel) < CHANNELS);
        new_item.channel  = s_channel;
        new_item.sample   = s_sample;
    end

    always_comb begin
        count_next = count_reg;
        if (push && !pop_ok) begin
            count_next = count_reg + 2'd1;
        end else if (pop_ok && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop_ok) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

### src/mma_ring.sv
// ----------------------------------------------------------------------------
// mma_ring
// Per-channel sample ring and running sum: read oldest, then write and update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_ring
    import mma_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS,
    parameter int WINDOW   = DEF_WINDOW
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               load,
    input  item_t                              item,
    output logic                               sum_valid,
    output logic [SAMPLE_W+$clog2(WINDOW)-1:0] sum_out
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = CH_IW + IDX_W;
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

    logic [SAMPLE_W-1:0] mem [2**ADDR_W];

    logic [IDX_W-1:0]    widx_reg [CHANNELS];
    logic [CHANNELS-1:0] wrapped_reg;       // ring has been filled once
    logic [SUM_W-1:0]    sum_reg  [CHANNELS];

    logic                s1_valid_reg;
    logic                s1_in_range_reg;
    logic [CH_IW-1:0]    s1_ch_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    logic                s1_old_ok_reg;
    logic [SAMPLE_W-1:0] rdata_reg;

    logic                sum_valid_reg;
    logic [SUM_W-1:0]    sum_out_reg;

    logic [CH_IW-1:0]    ch_idx;
    logic [IDX_W-1:0]    head_idx;
    logic [IDX_W-1:0]    idx_next;
    logic [ADDR_W-1:0]   rd_addr;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SUM_W-1:0]    new_sum;
    logic                commit;

    assign ch_idx   = CH_IW'(item.channel);
    assign head_idx = widx_reg[ch_idx];
    assign idx_next = (head_idx == LAST_IDX) ? '0 : head_idx + IDX_W'(1);
    assign rd_addr  = {ch_idx, head_idx};

    // A slot never written yet is read as zero through the filled flag
    assign old_sample = s1_old_ok_reg ? rdata_reg : '0;
    assign new_sum    = sum_reg[s1_ch_reg] - SUM_W'(old_sample) + SUM_W'(s1_sample_reg);
    assign commit     = en && s1_valid_reg && s1_in_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
            wrapped_reg   <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                widx_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end else begin
            if (en) begin
                s1_valid_reg  <= load;
                sum_valid_reg <= s1_valid_reg;
            end
            if (load && item.in_range) begin
                widx_reg[ch_idx] <= idx_next;
                if (head_idx == LAST_IDX) begin
                    wrapped_reg[ch_idx] <= 1'b1;
                end
            end
            if (commit) begin
                sum_reg[s1_ch_reg] <= new_sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            s1_in_range_reg <= item.in_range;
            s1_ch_reg       <= ch_idx;
            s1_sample_reg   <= item.sample;
            s1_addr_reg     <= rd_addr;
            s1_old_ok_reg   <= wrapped_reg[ch_idx];
        end
        if (en) begin
            sum_out_reg <= s1_in_range_reg ? new_sum : '0;
        end
    end

    // Sample memory: one read, one write per cycle
    always_ff @(posedge aclk) begin
        if (load) begin
            rdata_reg <= mem[rd_addr];
        end
        if (commit) begin
            mem[s1_addr_reg] <= s1_sample_reg;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum_out   = sum_out_reg;

endmodule

### src/mma_div.sv
// ----------------------------------------------------------------------------
// mma_div
// Divide window sum by WINDOW: reciprocal multiply, one correction step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mma_div
    import mma_pkg::*;
#(
    parameter int WINDOW = DEF_WINDOW
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [SAMPLE_W+$clog2(WINDOW)-1:0] in_sum,
    output logic                               out_valid,
    output logic [AVERAGE_W-1:0]               out_average
);

    localparam int SUM_W = SAMPLE_W + $clog2(WINDOW);
    // floor(2^SUM_W / WINDOW): estimate is the quotient or one below it
    localparam logic [SUM_W-1:0] RECIP = SUM_W'((1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WIN_C = SUM_W'(WINDOW);

    logic [2*SUM_W-1:0]   prod;
    logic [SUM_W-1:0]     qw;
    logic [SUM_W-1:0]     rem;

    logic                 v1_reg;
    logic [SUM_W-1:0]     sum1_reg;
    logic [AVERAGE_W-1:0] q1_reg;
    logic                 v2_reg;
    logic [SUM_W-1:0]     sum2_reg;
    logic [AVERAGE_W-1:0] q2_reg;
    logic [SUM_W-1:0]     qw2_reg;
    logic                 out_valid_reg;
    logic [AVERAGE_W-1:0] avg_reg;
    logic [AVERAGE_W-1:0] avg_next;

    assign prod = (2*SUM_W)'(in_sum) * (2*SUM_W)'(RECIP);
    assign qw   = SUM_W'(q1_reg) * WIN_C;
    assign rem  = sum2_reg - qw2_reg;
    assign avg_next = (rem >= WIN_C) ? q2_reg + AVERAGE_W'(1) : q2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg        <= in_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum1_reg <= in_sum;
            q1_reg   <= AVERAGE_W'(prod[2*SUM_W-1:SUM_W]);
            sum2_reg <= sum1_reg;
            q2_reg   <= q1_reg;
            qw2_reg  <= qw;
            avg_reg  <= avg_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_average = avg_reg;

endmodule
